// ===== hw/rtl/zbh_pkg.sv =====
// shared constants, types and helpers of the zobrist board hash block
package zbh_pkg;

  localparam int unsigned KeyW       = 64;
  localparam int unsigned KeyIdxW    = 10;
  localparam int unsigned SquareW    = 6;
  localparam int unsigned CastleW    = 4;
  localparam int unsigned PieceTypeW = 3;

  localparam int unsigned PieceKeys   = 768;
  localparam int unsigned CastleKeys  = 16;
  localparam int unsigned PassantKeys = 64;

  localparam logic [KeyIdxW-1:0] KeyCount    = 10'd849;
  localparam logic [KeyIdxW-1:0] CastleBase  = 10'd768;
  localparam logic [KeyIdxW-1:0] PassantBase = 10'd784;
  localparam logic [KeyIdxW-1:0] SideIndex   = 10'd848;

  localparam logic [KeyW-1:0] GenSeed = 64'd22122003;
  localparam logic [KeyW-1:0] GenMult = 64'd2685821657736338717;

  localparam int unsigned GenShiftA = 12;
  localparam int unsigned GenShiftB = 25;
  localparam int unsigned GenShiftC = 27;

  localparam logic [PieceTypeW-1:0] PieceTypeMin = 3'd1;
  localparam logic [PieceTypeW-1:0] PieceTypeMax = 3'd6;

  // one key write from the generator into the store
  typedef struct packed {
    logic               vld;
    logic [KeyIdxW-1:0] idx;
    logic [KeyW-1:0]    key;
  } key_wr_t;

  // lookup request, one per accepted square
  typedef struct packed {
    logic               re;
    logic [KeyIdxW-1:0] piece_addr;
    logic [CastleW-1:0] castle_sel;
    logic [SquareW-1:0] passant_sq;
  } key_rd_req_t;

  // registered lookup data
  typedef struct packed {
    logic [KeyW-1:0] piece;
    logic [KeyW-1:0] castle;
    logic [KeyW-1:0] passant;
    logic [KeyW-1:0] side;
  } key_rd_t;

  // xorshift step of the key generator
  function automatic logic [KeyW-1:0] xorshift(input logic [KeyW-1:0] w);
    logic [KeyW-1:0] t;
    t = w ^ (w >> GenShiftA);
    t = t ^ (t << GenShiftB);
    t = t ^ (t >> GenShiftC);
    return t;
  endfunction

endpackage

// ===== hw/rtl/zobrist_board_hash_core.sv =====
// top level of the zobrist board hash block
// Computes the 64-bit Zobrist hash of a chess position sent one square per
// transfer on the slave stream. tdata carries the square, piece and the
// side/castling/en-passant fields; tlast marks the final square of a board.
// On that transfer the side, castling and en-passant keys are folded in and
// the hash leaves on the master stream as one 64-bit transfer; the running
// hash then starts again from zero.
// After reset the key generator writes one key per cycle into the store,
// 849 keys through a multiply pipeline, and s_axis_tready_o stays low
// until the last key has been written.
// One square per cycle while no stall holds the input, set by the single
// read port of the piece key ram. The final square's keys are read on the
// accepting edge into stage s1, then accumulated into the output register;
// a stall holds the final square in s1 until the hash ahead is taken.
// When the master side stalls, squares of the next board keep flowing; only
// a second final square waiting behind an untaken hash holds tready low.
module zobrist_board_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] square_index, [6] piece_present, [9:7] piece_type,
  // [10] piece_color, [11] black_to_move, [15:12] castle_rights,
  // [16] passant_valid, [22:17] passant_square, [23] zero
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [63:0] board_hash
  output logic [63:0] m_axis_tdata_o
);

  zbh_pkg::key_wr_t     key_wr;
  zbh_pkg::key_rd_req_t rd_req;
  zbh_pkg::key_rd_t     rd;
  logic                 fill_done;

  logic [zbh_pkg::SquareW-1:0]    sq;
  logic                           present;
  logic [zbh_pkg::PieceTypeW-1:0] ptype;
  logic [zbh_pkg::PieceTypeW-1:0] ptype_m1;
  logic                           color;
  logic                           piece_ok;

  logic s_fire, stall, s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic s1_piece_q, s1_last_q, s1_black_q, s1_ep_q;

  logic [zbh_pkg::KeyW-1:0] acc_q, acc_d;
  logic [zbh_pkg::KeyW-1:0] piece_term, final_hash;
  logic                     out_valid_q, out_valid_d;
  logic [zbh_pkg::KeyW-1:0] out_data_q, out_data_d;

  zbh_keygen u_keygen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_wr_o    (key_wr),
    .fill_done_o (fill_done)
  );

  zbh_key_store u_key_store (
    .clk_i    (clk_i),
    .key_wr_i (key_wr),
    .rd_req_i (rd_req),
    .rd_o     (rd)
  );

  assign sq       = s_axis_tdata_i[5:0];
  assign present  = s_axis_tdata_i[6];
  assign ptype    = s_axis_tdata_i[9:7];
  assign color    = s_axis_tdata_i[10];
  assign ptype_m1 = ptype - 3'd1;
  assign piece_ok = present && (ptype >= zbh_pkg::PieceTypeMin)
                    && (ptype <= zbh_pkg::PieceTypeMax);

  // only a final square meeting an untaken hash has to wait
  assign stall  = s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready_i;
  assign s_axis_tready_o = fill_done && !stall;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_adv = s1_valid_q && !stall;

  assign rd_req.re         = s_fire;
  assign rd_req.piece_addr = {ptype_m1, color, sq};
  assign rd_req.castle_sel = s_axis_tdata_i[15:12];
  assign rd_req.passant_sq = s_axis_tdata_i[22:17];

  assign s1_valid_d = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  assign piece_term = s1_piece_q ? rd.piece : '0;
  assign final_hash = acc_q ^ piece_term ^ rd.castle
                      ^ (s1_black_q ? rd.side : '0)
                      ^ (s1_ep_q ? rd.passant : '0);

  always_comb begin
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (s1_adv) begin
      if (s1_last_q) begin
        acc_d       = '0;
        out_data_d  = final_hash;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_q ^ piece_term;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_piece_q <= piece_ok;
      s1_last_q  <= s_axis_tlast_i;
      s1_black_q <= s_axis_tdata_i[11];
      s1_ep_q    <= s_axis_tdata_i[16];
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_no_accept_during_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> fill_done)
    else $error("square taken before key fill finished");

  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("hash emitted without a final square");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> s1_valid_q && s1_last_q)
    else $error("final square lost during output stall");

  a_key_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr.vld |-> (key_wr.idx < zbh_pkg::KeyCount))
    else $error("key write beyond store");
`endif

endmodule

// ===== hw/rtl/zbh_ram.sv =====
// generic single-write, single-read ram with registered read data
module zbh_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/zbh_keygen.sv =====
// xorshift64* key generator that fills the key store after reset
module zbh_keygen (
  input  logic            clk_i,
  input  logic            rst_ni,
  output zbh_pkg::key_wr_t key_wr_o,
  output logic            fill_done_o
);

  logic [zbh_pkg::KeyIdxW-1:0] gen_cnt_q, gen_cnt_d;
  logic [zbh_pkg::KeyW-1:0]    word_q, word_d;
  logic                        run;

  logic                        a_vld_q, b_vld_q, c_vld_q;
  logic [zbh_pkg::KeyIdxW-1:0] a_idx_q, b_idx_q, c_idx_q;
  logic [63:0]                 p_ll_q;
  logic [31:0]                 p_lh_q, p_hl_q;
  logic [63:0]                 p_ll_d;
  logic [31:0]                 p_lh_d, p_hl_d;
  logic [zbh_pkg::KeyW-1:0]    key_q, key_d;
  logic                        done_q, done_d;

  assign run       = (gen_cnt_q != zbh_pkg::KeyCount);
  assign gen_cnt_d = run ? gen_cnt_q + 10'd1 : gen_cnt_q;
  assign word_d    = run ? zbh_pkg::xorshift(word_q) : word_q;

  // 64x64 product modulo 2^64 from three 32x32 partial products
  assign p_ll_d = word_q[31:0] * zbh_pkg::GenMult[31:0];
  assign p_lh_d = word_q[31:0] * zbh_pkg::GenMult[63:32];
  assign p_hl_d = word_q[63:32] * zbh_pkg::GenMult[31:0];
  assign key_d  = p_ll_q + {p_lh_q + p_hl_q, 32'd0};

  assign done_d = done_q | (c_vld_q && (c_idx_q == zbh_pkg::SideIndex));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_cnt_q <= '0;
      word_q    <= zbh_pkg::GenSeed;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      gen_cnt_q <= gen_cnt_d;
      word_q    <= word_d;
      a_vld_q   <= run;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q <= gen_cnt_q;
    b_idx_q <= a_idx_q;
    c_idx_q <= b_idx_q;
    p_ll_q  <= p_ll_d;
    p_lh_q  <= p_lh_d;
    p_hl_q  <= p_hl_d;
    key_q   <= key_d;
  end

  assign key_wr_o.vld = c_vld_q;
  assign key_wr_o.idx = c_idx_q;
  assign key_wr_o.key = key_q;
  assign fill_done_o  = done_q;

endmodule

// ===== hw/rtl/zbh_key_store.sv =====
// key store: piece and en-passant rams, castling and side key registers
module zbh_key_store (
  input  logic                  clk_i,
  input  zbh_pkg::key_wr_t      key_wr_i,
  input  zbh_pkg::key_rd_req_t  rd_req_i,
  output zbh_pkg::key_rd_t      rd_o
);

  logic                     piece_we, passant_we, castle_we, side_we;
  logic [9:0]               passant_off;
  logic [zbh_pkg::KeyW-1:0] castle_q [zbh_pkg::CastleKeys];
  logic [zbh_pkg::KeyW-1:0] castle_rd_q;
  logic [zbh_pkg::KeyW-1:0] side_q;
  logic [zbh_pkg::KeyW-1:0] piece_rd, passant_rd;

  assign piece_we   = key_wr_i.vld && (key_wr_i.idx < zbh_pkg::CastleBase);
  assign castle_we  = key_wr_i.vld && (key_wr_i.idx >= zbh_pkg::CastleBase)
                      && (key_wr_i.idx < zbh_pkg::PassantBase);
  assign passant_we = key_wr_i.vld && (key_wr_i.idx >= zbh_pkg::PassantBase)
                      && (key_wr_i.idx < zbh_pkg::SideIndex);
  assign side_we    = key_wr_i.vld && (key_wr_i.idx == zbh_pkg::SideIndex);
  assign passant_off = key_wr_i.idx - zbh_pkg::PassantBase;

  zbh_ram #(
    .Width (zbh_pkg::KeyW),
    .Depth (zbh_pkg::PieceKeys)
  ) u_piece_ram (
    .clk_i   (clk_i),
    .we_i    (piece_we),
    .waddr_i (key_wr_i.idx),
    .wdata_i (key_wr_i.key),
    .re_i    (rd_req_i.re),
    .raddr_i (rd_req_i.piece_addr),
    .rdata_o (piece_rd)
  );

  zbh_ram #(
    .Width (zbh_pkg::KeyW),
    .Depth (zbh_pkg::PassantKeys)
  ) u_passant_ram (
    .clk_i   (clk_i),
    .we_i    (passant_we),
    .waddr_i (passant_off[5:0]),
    .wdata_i (key_wr_i.key),
    .re_i    (rd_req_i.re),
    .raddr_i (rd_req_i.passant_sq),
    .rdata_o (passant_rd)
  );

  always_ff @(posedge clk_i) begin
    if (castle_we) begin
      castle_q[key_wr_i.idx[3:0]] <= key_wr_i.key;
    end
    if (side_we) begin
      side_q <= key_wr_i.key;
    end
    if (rd_req_i.re) begin
      castle_rd_q <= castle_q[rd_req_i.castle_sel];
    end
  end

  assign rd_o.piece   = piece_rd;
  assign rd_o.castle  = castle_rd_q;
  assign rd_o.passant = passant_rd;
  assign rd_o.side    = side_q;

endmodule

// ===== verif/tb.sv =====
// testbench of the zobrist board hash core: stream stimulus checked against a key-table predictor
module tb;

  typedef struct packed {
    logic [zbh_pkg::SquareW-1:0]    sq;
    logic                           present;
    logic [zbh_pkg::PieceTypeW-1:0] ptype;
    logic                           color;
    logic                           black;
    logic [zbh_pkg::CastleW-1:0]    castle;
    logic                           ep_valid;
    logic [zbh_pkg::SquareW-1:0]    ep_sq;
    logic                           is_last;
  } square_t;

  localparam int unsigned TotalItems  = 1450;
  localparam int unsigned QuietTail   = 200;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [63:0] m_axis_tdata_o;

  logic [zbh_pkg::KeyW-1:0] key_ram [0:zbh_pkg::KeyCount-1];
  logic [zbh_pkg::KeyW-1:0] board_acc = '0;
  logic [zbh_pkg::KeyW-1:0] pending_hashes [$];
  logic                     idle_on = 1'b1;
  int                       mismatches = 0;
  int                       stall_left = 0;
  int                       idle_cycles = 0;

  // sq, present, ptype, color, black, castle, ep_valid, ep_sq, is_last
  square_t plan [22] = '{
    '{6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b1}, // empty board
    '{6'd63, 1'b1, 3'd1, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd0,  1'b1, 3'd6, 1'b1, 1'b1, 4'd15, 1'b1, 6'd63, 1'b0}, // side fields ignored mid-board
    '{6'd5,  1'b1, 3'd0, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0}, // bad type reads as empty
    '{6'd9,  1'b1, 3'd7, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd17, 1'b0, 3'd5, 1'b1, 1'b0, 4'd0,  1'b0, 6'd63, 1'b1}, // empty, passant square ignored
    '{6'd63, 1'b1, 3'd7, 1'b1, 1'b1, 4'd15, 1'b1, 6'd63, 1'b1},
    '{6'd0,  1'b0, 3'd0, 1'b0, 1'b0, 4'd0,  1'b1, 6'd0,  1'b1},
    '{6'd1,  1'b1, 3'd1, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd2,  1'b1, 3'd1, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd3,  1'b1, 3'd2, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd4,  1'b1, 3'd2, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd10, 1'b1, 3'd3, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd20, 1'b1, 3'd3, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd30, 1'b1, 3'd4, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd40, 1'b1, 3'd4, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd50, 1'b1, 3'd5, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd60, 1'b1, 3'd5, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd62, 1'b1, 3'd6, 1'b0, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0},
    '{6'd61, 1'b1, 3'd6, 1'b1, 1'b1, 4'd10, 1'b1, 6'd40, 1'b1},
    '{6'd33, 1'b1, 3'd4, 1'b1, 1'b0, 4'd0,  1'b0, 6'd0,  1'b0}, // same piece twice cancels
    '{6'd33, 1'b1, 3'd4, 1'b1, 1'b1, 4'd5,  1'b0, 6'd0,  1'b1}
  };

  zobrist_board_hash_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %016h want %016h", $realtime, what, got, want);
    mismatches++;
  endtask

  // drives one square and folds it into the running board hash once it is taken
  task automatic send_square(input square_t s);
    logic [zbh_pkg::KeyW-1:0] h;
    int                       idx;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, s.ep_sq, s.ep_valid, s.castle, s.black, s.color,
                        s.ptype, s.present, s.sq};
    s_axis_tlast_i  <= s.is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    h = board_acc;
    if (s.present && s.ptype >= zbh_pkg::PieceTypeMin
        && s.ptype <= zbh_pkg::PieceTypeMax) begin
      idx = ((int'(s.ptype) - 1) * 2 + int'(s.color)) * 64 + int'(s.sq);
      h ^= key_ram[idx];
    end
    if (s.is_last) begin
      if (s.black) h ^= key_ram[zbh_pkg::SideIndex];
      h ^= key_ram[zbh_pkg::CastleBase + s.castle];
      if (s.ep_valid) h ^= key_ram[zbh_pkg::PassantBase + s.ep_sq];
      pending_hashes.push_back(h);
      h = '0;
    end
    board_acc = h;
  endtask

  // result side: compare each transfer, and stall in random bursts
  always @(posedge clk_i) begin : sink
    logic [zbh_pkg::KeyW-1:0] want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("board_hash with no board pending", m_axis_tdata_o, '0);
      end else begin
        want = pending_hashes.pop_front();
        if (m_axis_tdata_o !== want) report_mismatch("board_hash", m_axis_tdata_o, want);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) m_axis_tready_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left = $urandom_range(1, 15);
    end
  end

  // watchdog: long stretch with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("zobrist_board_hash_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [zbh_pkg::KeyW-1:0] w;
    int                       sent;
    w = zbh_pkg::GenSeed;
    for (int i = 0; i < int'(zbh_pkg::KeyCount); i++) begin
      w ^= w >> zbh_pkg::GenShiftA;
      w ^= w << zbh_pkg::GenShiftB;
      w ^= w >> zbh_pkg::GenShiftC;
      key_ram[i] = w * zbh_pkg::GenMult;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) send_square(plan[i]);
    sent = $size(plan);

    // random boards: mostly short scattered ones, some full 64-square sweeps
    while (sent < TotalItems) begin
      int      kind;
      int      len;
      square_t s;
      kind    = $urandom_range(0, 9);
      idle_on = (sent < TotalItems - QuietTail) && ($urandom_range(0, 4) != 0);
      if (kind == 0) len = 64;
      else if (kind == 1) len = $urandom_range(1, 2);
      else len = $urandom_range(2, 30);
      for (int n = 0; n < len; n++) begin
        s         = 24'($urandom);
        s.sq      = (kind == 0) ? 6'(n) : 6'($urandom_range(0, 63));
        s.present = ($urandom_range(0, 9) < 6);
        s.ptype   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 1) * 7)
                                                : 3'($urandom_range(1, 6));
        s.is_last = (n == len - 1);
        send_square(s);
      end
      sent += len;
    end
    idle_on = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    wait (pending_hashes.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("zobrist_board_hash_core verification clean");
    end else begin
      $display("zobrist_board_hash_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/zbh_pkg.sv
hw/rtl/zbh_ram.sv
hw/rtl/zbh_keygen.sv
hw/rtl/zbh_key_store.sv
hw/rtl/zobrist_board_hash_core.sv
verif/tb.sv
